FILE: hdl/pqs_pkg.sv
// Package: shared constants, counter entry layout and size bucket decode.
package pqs_pkg;

  localparam int QUEUES    = 1024;
  localparam int ENTRIES   = 2 * QUEUES;
  localparam int ENTRY_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BUCKETS   = 5;
  localparam int NAME_W    = 64;
  localparam int QUEUE_W   = 16;
  localparam int LEN_W     = 32;
  localparam int BYTES_W   = 64;
  localparam int COUNT_W   = 32;

  // Register indexes on the configuration port.
  localparam logic REG_FILTER_FIRST  = 1'b0;
  localparam logic REG_FILTER_SECOND = 1'b1;

  // Upper bounds of the size buckets, in bytes.
  localparam logic [LEN_W-1:0] BOUND_64  = 32'd64;
  localparam logic [LEN_W-1:0] BOUND_512 = 32'd512;
  localparam logic [LEN_W-1:0] BOUND_2K  = 32'd2048;
  localparam logic [LEN_W-1:0] BOUND_16K = 32'd16384;
  localparam logic [LEN_W-1:0] BOUND_64K = 32'd65536;

  typedef struct packed {
    logic [BYTES_W-1:0]              byte_total;
    logic [COUNT_W-1:0]              packet_total;
    logic [BUCKETS-1:0][COUNT_W-1:0] buckets;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // One-hot mask of the first bucket whose bound lies above len; zero when none.
  function automatic logic [BUCKETS-1:0] bucket_hit(input logic [LEN_W-1:0] len);
    logic [BUCKETS-1:0] hit;
    hit = '0;
    if (len < BOUND_64) begin
      hit[0] = 1'b1;
    end else if (len < BOUND_512) begin
      hit[1] = 1'b1;
    end else if (len < BOUND_2K) begin
      hit[2] = 1'b1;
    end else if (len < BOUND_16K) begin
      hit[3] = 1'b1;
    end else if (len < BOUND_64K) begin
      hit[4] = 1'b1;
    end
    return hit;
  endfunction

endpackage

FILE: hdl/pqs_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module pqs_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/pqs_update.sv
// Counter update: add one packet of a given length to a read-back entry.
module pqs_update
  import pqs_pkg::*;
(
  input  entry_t           old_entry,
  input  logic [LEN_W-1:0] len,
  output entry_t           new_entry
);

  logic [BUCKETS-1:0] hit;

  assign hit = bucket_hit(len);

  always_comb begin
    new_entry.byte_total   = old_entry.byte_total + BYTES_W'(len);
    new_entry.packet_total = old_entry.packet_total + COUNT_W'(1);
    for (int b = 0; b < BUCKETS; b++) begin
      new_entry.buckets[b] = old_entry.buckets[b] + COUNT_W'(hit[b]);
    end
  end

endmodule

FILE: hdl/per_queue_packet_stats.sv
// Top level: per-queue packet counters with a size histogram, held in one RAM.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  input    | in_valid / in_ready        | device_name_first/second, direction,
//           |                            | queue_id, packet_length
//  output   | out_valid / out_ready      | accepted, byte_total, packet_total,
//           |                            | count_under_64 .. count_under_64k
//  config   | psel/penable/pwrite/pready | paddr[3] picks filter word, pwdata 64 bits
//
// For each event the transfer cycle issues the RAM read (matching events only);
// S_UPDATE then, once the output register is free, updates the entry, writes it
// back if the event matched and loads the output register. The next event is not
// taken until the write-back is done, so no two accesses to one entry overlap.
// After reset a clearing pass writes zero to all 2048 entries, one per cycle,
// and in_ready stays low until the pass is done; config writes work throughout.
// If the output register still holds an untaken result, hold the write-back
// until it is taken; a new event may be taken while a result waits.
module per_queue_packet_stats
  import pqs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  // event input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NAME_W-1:0]   device_name_first,
  input  logic [NAME_W-1:0]   device_name_second,
  input  logic                direction,
  input  logic [QUEUE_W-1:0]  queue_id,
  input  logic [LEN_W-1:0]    packet_length,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output logic                accepted,
  output logic [BYTES_W-1:0]  byte_total,
  output logic [COUNT_W-1:0]  packet_total,
  output logic [COUNT_W-1:0]  count_under_64,
  output logic [COUNT_W-1:0]  count_under_512,
  output logic [COUNT_W-1:0]  count_under_2k,
  output logic [COUNT_W-1:0]  count_under_16k,
  output logic [COUNT_W-1:0]  count_under_64k
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_UPDATE} state_t;

  state_t               state;
  logic [ENTRY_W-1:0]   clr_addr;
  logic [NAME_W-1:0]    filter_name_first;
  logic [NAME_W-1:0]    filter_name_second;

  // latched event
  logic                 hit;
  logic [ENTRY_W-1:0]   addr;
  logic [LEN_W-1:0]     len;

  logic                 in_xfer;
  logic                 out_free;
  logic                 match;
  logic [ENTRY_W-1:0]   in_addr;
  logic                 ram_we;
  logic [ENTRY_W-1:0]   ram_waddr;
  entry_t               ram_wdata;
  entry_t               rd_entry;
  entry_t               upd_entry;
  logic [ENTRY_BITS-1:0] ram_rdata;

  assign pready = 1'b1;

  // Configuration registers: paddr[3] selects the filter word.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_name_first  <= '0;
      filter_name_second <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3])
        REG_FILTER_FIRST:  filter_name_first  <= pwdata;
        REG_FILTER_SECOND: filter_name_second <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_FILTER_FIRST:  prdata = filter_name_first;
      REG_FILTER_SECOND: prdata = filter_name_second;
      default:           prdata = '0;
    endcase
  end

  // Event qualification and entry index (direction picks the table half).
  assign match = (device_name_first == filter_name_first) &&
                 (device_name_second == filter_name_second) &&
                 ({1'b0, queue_id} < 17'(QUEUES));
  assign in_addr = ENTRY_W'(ENTRY_W'(direction) * ENTRY_W'(QUEUES) + ENTRY_W'(queue_id));

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // RAM write: clearing pass, or write-back of an accepted event.
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_UPDATE) && out_free && hit;
      ram_waddr = addr;
      ram_wdata = upd_entry;
    end
  end

  pqs_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (ENTRY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer && match),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  pqs_update u_update (
    .old_entry (rd_entry),
    .len       (len),
    .new_entry (upd_entry)
  );

  // Sequencer and output register; a rejected event reports all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop valid once the result is taken, unless a new one loads on this edge
      if (out_valid && out_ready && state != S_UPDATE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ENTRY_W'(1);
          if (clr_addr == ENTRY_W'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // advance only once the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            accepted  <= hit;
            if (hit) begin
              byte_total      <= upd_entry.byte_total;
              packet_total    <= upd_entry.packet_total;
              count_under_64  <= upd_entry.buckets[0];
              count_under_512 <= upd_entry.buckets[1];
              count_under_2k  <= upd_entry.buckets[2];
              count_under_16k <= upd_entry.buckets[3];
              count_under_64k <= upd_entry.buckets[4];
            end else begin
              byte_total      <= '0;
              packet_total    <= '0;
              count_under_64  <= '0;
              count_under_512 <= '0;
              count_under_2k  <= '0;
              count_under_16k <= '0;
              count_under_64k <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latch the event on its transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hit  <= match;
      addr <= in_addr;
      len  <= packet_length;
    end
  end

endmodule
